// ----- src/dmcds_pkg.sv -----
// Shared constants, command and status types for the direct-mapped cell set.
package dmcds_pkg;

   localparam int SLOTS_DEFAULT = 4096;
   localparam int SLOTS_MAX     = 4096;

   localparam int ACTION_W = 2;
   localparam int AXIS_W   = 26;
   localparam int Y_W      = 7;
   localparam int KEY_W    = 2 * AXIS_W + Y_W + 1;   // x, z, y, type
   localparam int ENTRY_W  = KEY_W + 1;              // occupied bit on top
   localparam int FOLD_W   = 32;
   localparam int HASH_W   = 12;                     // product bits 31..20

   localparam logic [FOLD_W-1:0] GOLDEN = 32'h9E37_79B1;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   typedef struct packed {
      logic capture;      // take the request into the datapath
      logic hash_load;    // register the golden-ratio product
      logic mem_read;     // read the addressed slot
      logic update;       // write back if needed and load the result
      logic finish;       // load a zero result after a clear
      logic sweep_step;   // zero one slot and advance the sweep counter
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic out_free;
      logic is_clear;
   } status_type;

endpackage

// ----- src/dmcds_datapath.sv -----
// Datapath: key packing, hash, slot memory, sweep counter and result register.
module dmcds_datapath #(
   parameter int SLOTS = dmcds_pkg::SLOTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dmcds_pkg::cmd_type                     cmd,
   output dmcds_pkg::status_type                  st,
   input  logic [dmcds_pkg::ACTION_W-1:0]         req_action,
   input  logic                                   req_light_type,
   input  logic signed [dmcds_pkg::AXIS_W-1:0]    req_cell_x,
   input  logic [dmcds_pkg::Y_W-1:0]              req_cell_y,
   input  logic signed [dmcds_pkg::AXIS_W-1:0]    req_cell_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_was_new
);
   import dmcds_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [HASH_W-1:0] SLOT_MASK = HASH_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);

   logic [ENTRY_W-1:0] slot_mem [SLOTS];

   logic [ENTRY_W-1:0]  entry_in;
   logic [63:0]         full_key;
   logic [FOLD_W-1:0]   fold_in;
   logic [ENTRY_W-1:0]  entry_ff;
   logic [FOLD_W-1:0]   fold_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [FOLD_W-1:0]   product_in, product_ff;
   logic [HASH_W-1:0]   hash_masked;
   logic [IDX_W-1:0]    idx_in, idx_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_was_new_ff, rsp_was_new_in;

   logic                hit;
   logic                upd_write;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;

   // pack the key: occupied, x, z, y, type; bits 62..60 stay zero
   assign entry_in = {1'b1, req_cell_x, req_cell_z, req_cell_y, req_light_type};
   assign full_key = {1'b1, 3'b000, entry_in[KEY_W-1:0]};
   assign fold_in  = full_key[31:0] ^ full_key[63:32];

   assign product_in  = fold_ff * GOLDEN;
   assign hash_masked = product_ff[31:20] & SLOT_MASK;
   assign idx_in      = hash_masked[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_ff  <= entry_in;
         fold_ff   <= fold_in;
         action_ff <= req_action;
      end
      if (cmd.hash_load) begin
         product_ff <= product_in;
      end
   end

   assign hit = (rd_data_ff == entry_ff);

   always_comb begin
      upd_write = 1'b0;
      unique case (action_ff)
         ACT_INSERT: upd_write = !hit;
         ACT_ERASE:  upd_write = hit;
         default:    upd_write = 1'b0;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      priority if (cmd.sweep_step) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff;
      end else if (cmd.update && upd_write) begin
         mem_we    = 1'b1;
         mem_wdata = (action_ff == ACT_INSERT) ? entry_ff : '0;
      end else begin
         mem_we    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= slot_mem[idx_in];
         idx_ff     <= idx_in;
      end
   end

   // sweep counter wraps to zero after the last slot
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.sweep_step) begin
         cnt_in = (cnt_ff == LAST_IDX) ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_was_new_in = rsp_was_new_ff;
      priority if (cmd.update || cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_was_new_in = cmd.update && (action_ff == ACT_INSERT) && !hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_was_new_ff <= rsp_was_new_in;
   end

   assign st.sweep_last = (cnt_ff == LAST_IDX);
   assign st.out_free   = !rsp_valid_ff || rsp_ready;
   assign st.is_clear   = (action_ff == ACT_CLEAR);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_was_new = rsp_was_new_ff;

endmodule

// ----- src/dmcds_ctrl.sv -----
// Controller: sequences clearing sweeps, hash, slot read and update.
module dmcds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dmcds_pkg::status_type st,
   output dmcds_pkg::cmd_type    cmd
);
   import dmcds_pkg::*;

   localparam logic [2:0] ST_INIT_SWEEP  = 3'd0;
   localparam logic [2:0] ST_IDLE        = 3'd1;
   localparam logic [2:0] ST_HASH        = 3'd2;
   localparam logic [2:0] ST_READ        = 3'd3;
   localparam logic [2:0] ST_UPDATE      = 3'd4;
   localparam logic [2:0] ST_CLEAR_SWEEP = 3'd5;
   localparam logic [2:0] ST_FINISH      = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (st.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_load = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            priority if (st.is_clear) begin
               state_in = ST_CLEAR_SWEEP;
            end else if (st.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               // hold until the result register frees
               state_in = ST_UPDATE;
            end
         end
         ST_CLEAR_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (st.sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_INIT_SWEEP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_quick_result: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !(cmd.update || cmd.finish))
      else $error("result loaded the cycle after a request transfer");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.update || cmd.finish) |-> st.out_free)
      else $error("result loaded over an untaken result");

   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sweep_step && cmd.capture))
      else $error("request taken during a clearing sweep");

endmodule

// ----- src/direct_mapped_cell_dedup_set_core.sv -----
// Top level of the direct-mapped cell set: controller and datapath.
// An insert or erase result goes through the hash, read and update states; update waits for a free result register.
// A new request is taken only in the idle state, after the hash multiply, slot read and update of the last one.
// A clear zeroes one slot a cycle, then loads a zero result once the result register is free.
// Reset: synchronous; a clearing pass over every slot follows, req_ready stays low.
// The result register lets a finished result wait while the next request is taken.
module direct_mapped_cell_dedup_set_core #(
   parameter int SLOTS = dmcds_pkg::SLOTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dmcds_pkg::ACTION_W-1:0]         req_action,
   input  logic                                   req_light_type,
   input  logic signed [dmcds_pkg::AXIS_W-1:0]    req_cell_x,
   input  logic [dmcds_pkg::Y_W-1:0]              req_cell_y,
   input  logic signed [dmcds_pkg::AXIS_W-1:0]    req_cell_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_was_new
);
   import dmcds_pkg::*;

   cmd_type    cmd;
   status_type st;

   dmcds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   dmcds_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_action     (req_action),
      .req_light_type (req_light_type),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_z     (req_cell_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_was_new    (rsp_was_new)
   );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the direct-mapped cell dedup set core.
`timescale 1ns / 100ps

module tb_top;
   import dmcds_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 10;
   localparam int SHOW_LIMIT  = 10;
   localparam int POOL_DEPTH  = 48;

   localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

   typedef struct packed {
      logic              light;
      logic [AXIS_W-1:0] x;
      logic [Y_W-1:0]    y;
      logic [AXIS_W-1:0] z;
   } cell_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action     = ACT_INSERT;
   logic                req_light_type = 1'b0;
   logic [AXIS_W-1:0]   req_cell_x     = '0;
   logic [Y_W-1:0]      req_cell_y     = '0;
   logic [AXIS_W-1:0]   req_cell_z     = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic                rsp_was_new;

   // shadow of the slot table, one 64-bit key word per slot
   logic [63:0] shadow_slots [SLOTS];
   logic        was_new_due [$];
   cell_type    recent_cells [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked    = 0;
   int hold_taken    = 0;
   int hold_left     = 0;
   int fault_count   = 0;
   logic due_bit;

   direct_mapped_cell_dedup_set_core #(.SLOTS(SLOTS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_light_type (req_light_type),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_z     (req_cell_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_was_new    (rsp_was_new)
   );

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= SHOW_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Apply one action to the shadow table and return the expected was_new.
   function automatic logic predict_was_new(input logic [ACTION_W-1:0] action,
                                            input cell_type c);
      logic [63:0] key;
      logic [31:0] folded;
      logic [31:0] mixed;
      int unsigned idx;
      logic        fresh;
      key    = {1'b1, 3'b000, c.x, c.z, c.y, c.light};
      folded = key[31:0] ^ key[63:32];
      mixed  = folded * GOLDEN;
      idx    = int'(mixed[31:20]) & (SLOTS - 1);
      fresh  = 1'b0;
      case (action)
         ACT_INSERT: begin
            if (shadow_slots[idx] != key) begin
               shadow_slots[idx] = key;
               fresh = 1'b1;
            end
         end
         ACT_ERASE: begin
            if (shadow_slots[idx] == key) shadow_slots[idx] = '0;
         end
         ACT_CLEAR: begin
            foreach (shadow_slots[i]) shadow_slots[i] = '0;
         end
         default: ;
      endcase
      return fresh;
   endfunction

   function automatic logic [AXIS_W-1:0] rand_axis();
      case ($urandom_range(15))
         0:       return {1'b1, {(AXIS_W-1){1'b0}}};
         1:       return {1'b0, {(AXIS_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return AXIS_W'($urandom);
      endcase
   endfunction

   function automatic cell_type rand_cell();
      cell_type c;
      c.light = 1'($urandom_range(1));
      c.x     = rand_axis();
      c.y     = Y_W'($urandom_range(127));
      c.z     = rand_axis();
      return c;
   endfunction

   // Flip paired bits in the two fold halves: different key, same slot.
   function automatic cell_type alias_of(input cell_type c);
      logic [AXIS_W-1:0] m;
      cell_type a;
      m = AXIS_W'($urandom_range(1, (1 << AXIS_W) - 1));
      a = c;
      a.x       ^= m;
      a.y       ^= {m[5:0], 1'b0};
      a.z[19:0] ^= m[25:6];
      if ($urandom_range(1)) begin
         a.z[24] ^= 1'b1;
         a.light ^= 1'b1;
      end
      return a;
   endfunction

   task automatic send_cell(input logic [ACTION_W-1:0] action, input cell_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_light_type <= c.light;
      req_cell_x     <= c.x;
      req_cell_y     <= c.y;
      req_cell_z     <= c.z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      was_new_due.push_back(predict_was_new(action, c));
   endtask

   task automatic remember(input cell_type c);
      if (recent_cells.size() >= POOL_DEPTH) void'(recent_cells.pop_front());
      recent_cells.push_back(c);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (was_new_due.size() != 0) @(posedge clock);
   endtask

   // One random operation, mostly on keys seen recently so that hits and aliases occur.
   task automatic send_mixed_op();
      int       roll;
      cell_type c;
      roll = $urandom_range(999);
      if (roll < 5) begin
         send_cell(ACT_CLEAR, rand_cell());
      end else if (roll < 40) begin
         send_cell(ACT_NOP, rand_cell());
      end else if (recent_cells.size() == 0 || roll < 420) begin
         c = rand_cell();
         send_cell(ACT_INSERT, c);
         remember(c);
      end else begin
         c = recent_cells[$urandom_range(recent_cells.size() - 1)];
         if (roll < 600) begin
            send_cell(ACT_INSERT, c);
         end else if (roll < 780) begin
            send_cell(ACT_ERASE, c);
         end else if (roll < 880) begin
            c = alias_of(c);
            send_cell(ACT_INSERT, c);
            remember(c);
         end else begin
            send_cell(ACT_ERASE, alias_of(c));
         end
      end
   endtask

   task automatic test_directed_cases();
      cell_type lo, hi, nil, ones, hi_alias;
      lo       = '{light: 1'b0, x: 26'h2000000, y: 7'h00, z: 26'h2000000};
      hi       = '{light: 1'b1, x: 26'h1FFFFFF, y: 7'h7F, z: 26'h1FFFFFF};
      nil      = '0;
      ones     = '{light: 1'b1, x: 26'h3FFFFFF, y: 7'h55, z: 26'h3FFFFFF};
      hi_alias = alias_of(hi);
      send_cell(ACT_INSERT, lo);
      send_cell(ACT_INSERT, lo);
      send_cell(ACT_INSERT, hi);
      send_cell(ACT_INSERT, hi);
      // all-zero coordinates must not match an empty slot
      send_cell(ACT_ERASE, nil);
      send_cell(ACT_INSERT, nil);
      send_cell(ACT_INSERT, nil);
      send_cell(ACT_ERASE, lo);
      send_cell(ACT_ERASE, lo);
      send_cell(ACT_INSERT, lo);
      // colliding insert evicts, then the evicted key comes back as new
      send_cell(ACT_INSERT, hi_alias);
      send_cell(ACT_INSERT, hi);
      send_cell(ACT_ERASE, hi_alias);
      send_cell(ACT_NOP, hi);
      send_cell(ACT_INSERT, hi);
      send_cell(ACT_INSERT, ones);
      send_cell(ACT_ERASE, ones);
      send_cell(ACT_INSERT, ones);
      send_cell(ACT_CLEAR, nil);
      send_cell(ACT_INSERT, hi);
      send_cell(ACT_INSERT, ones);
      send_cell(ACT_ERASE, hi);
      send_cell(ACT_CLEAR, ones);
      send_cell(ACT_NOP, lo);
      send_cell(ACT_INSERT, lo);
      remember(lo);
      remember(hi);
      remember(ones);
   endtask

   task automatic test_mixed_traffic(input int count);
      repeat (count) send_mixed_op();
   endtask

   // Hold the result side off while requests keep coming, so the input stalls.
   task automatic test_input_stall();
      int saved;
      saved         = send_idle_pct;
      send_idle_pct = 0;
      hold_asked++;
      repeat (40) send_mixed_op();
      send_idle_pct = saved;
   endtask

   task automatic test_pause_and_drain();
      repeat (20) send_mixed_op();
      wait_for_results();
      repeat (20) send_mixed_op();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         rsp_ready  <= 1'b0;
         hold_taken <= hold_taken + 1;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (was_new_due.size() == 0) begin
            report_fault($sformatf("result with nothing pending: was_new %0b", rsp_was_new));
         end else begin
            due_bit = was_new_due.pop_front();
            if (rsp_was_new !== due_bit) begin
               report_fault($sformatf("was_new mismatch: expected %0b, got %0b",
                                      due_bit, rsp_was_new));
            end
         end
      end
   end

   initial begin
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      send_idle_pct = 12;
      recv_idle_pct = 82;
      test_mixed_traffic(280);
      test_input_stall();
      send_idle_pct = 82;
      recv_idle_pct = 12;
      test_mixed_traffic(280);
      test_pause_and_drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_mixed_traffic(280);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (was_new_due.size() != 0) begin
         report_fault($sformatf("%0d results never arrived", was_new_due.size()));
      end
      if (fault_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/dmcds_pkg.sv
src/dmcds_datapath.sv
src/dmcds_ctrl.sv
src/direct_mapped_cell_dedup_set_core.sv
verif/tb_top.sv
